// ===== rtl/abb_pkg.sv =====
// ----------------------------------------------------------------------------
// abb_pkg: shared types and constants for the affine box bounds block
// Payload structs, register map and fixed-point widths.
// ----------------------------------------------------------------------------
package abb_pkg;

  localparam int unsigned NumAxes   = 3;
  localparam int unsigned CoordW    = 32;               // Q20.12 coordinate
  localparam int unsigned CoefW     = 16;               // Q4.12 coefficient
  localparam int unsigned FracBits  = 12;
  localparam int unsigned DiffW     = CoordW + 1;       // p - c
  localparam int unsigned ProdW     = CoefW + DiffW;    // one product
  localparam int unsigned SumW      = ProdW + 2;        // three products + bias
  localparam int unsigned RndW      = SumW - FracBits;  // after the shift
  localparam int unsigned ValW      = RndW + 1;         // plus t + c
  localparam int unsigned CoefRowW  = NumAxes * CoefW;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned CfgAddrW  = 6;

  localparam logic [SumW-1:0] RoundBias = SumW'(1) << (FracBits - 1);

  localparam logic [CoefRowW-1:0] CoefRowXRst = 48'h0000_0000_1000;
  localparam logic [CoefRowW-1:0] CoefRowYRst = 48'h0000_1000_0000;
  localparam logic [CoefRowW-1:0] CoefRowZRst = 48'h1000_0000_0000;

  typedef enum logic [2:0] {
    REG_COEFF_ROW_X = 3'd0,
    REG_COEFF_ROW_Y = 3'd1,
    REG_COEFF_ROW_Z = 3'd2,
    REG_OFFSETS_X   = 3'd3,
    REG_OFFSETS_Y   = 3'd4,
    REG_OFFSETS_Z   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] box_x_low;
    logic signed [CoordW-1:0] box_x_high;
    logic signed [CoordW-1:0] box_y_low;
    logic signed [CoordW-1:0] box_y_high;
    logic signed [CoordW-1:0] box_z_low;
    logic signed [CoordW-1:0] box_z_high;
  } box_t;

  typedef struct packed {
    logic signed [CoordW-1:0] mapped_x_low;
    logic signed [CoordW-1:0] mapped_x_high;
    logic signed [CoordW-1:0] mapped_y_low;
    logic signed [CoordW-1:0] mapped_y_high;
    logic signed [CoordW-1:0] mapped_z_low;
    logic signed [CoordW-1:0] mapped_z_high;
  } bounds_t;

endpackage

// ===== rtl/abb_stream_if.sv =====
// ----------------------------------------------------------------------------
// abb_stream_if: valid/ready stream channel
// Carries one payload per transfer; a transfer happens when valid and ready
// are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface abb_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/affine_box_bounds_3d.sv =====
// ----------------------------------------------------------------------------
// affine_box_bounds_3d: bounding box of an affine-mapped 3D box
//
// box_i takes one axis-aligned box (six signed Q20.12 bounds) per transfer.
// bounds_o returns, per axis, the min and max of the eight corners mapped as
// M*(p - c) + t + c, rounded and saturated to 32 bits. The matrix rows and
// the per-axis offsets sit in an APB register file (8-byte stride).
// Each output bound is found from per-term minima and maxima: rounding, the
// offset add and saturation are monotonic, so no corner is formed explicitly.
// The pipeline has five register stages: difference, products, per-term
// min/max, sums, and round/offset/saturate into the output register.
// A new box is accepted every cycle while box_i.ready is high. When
// the receiver stalls, the stages fill up behind
// the output register and box_i.ready drops only once every stage holds an
// item; nothing is dropped or repeated. Reset clears all stage valid bits and
// returns the registers to the identity map with zero offsets.
// Registers must only be written while no item is in flight.
// ----------------------------------------------------------------------------
module affine_box_bounds_3d
  import abb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  abb_stream_if.sink          box_i,
  abb_stream_if.source        bounds_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  // Register file.
  logic [CoefRowW-1:0] coef_q [NumAxes];
  logic [CfgDataW-1:0] offs_q [NumAxes];
  logic                cfg_wr;
  reg_idx_e            reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[CfgAddrW-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0] <= CoefRowXRst;
      coef_q[1] <= CoefRowYRst;
      coef_q[2] <= CoefRowZRst;
      for (int a = 0; a < NumAxes; a++) begin
        offs_q[a] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_COEFF_ROW_X: coef_q[0] <= pwdata[CoefRowW-1:0];
        REG_COEFF_ROW_Y: coef_q[1] <= pwdata[CoefRowW-1:0];
        REG_COEFF_ROW_Z: coef_q[2] <= pwdata[CoefRowW-1:0];
        REG_OFFSETS_X:   offs_q[0] <= pwdata;
        REG_OFFSETS_Y:   offs_q[1] <= pwdata;
        REG_OFFSETS_Z:   offs_q[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_COEFF_ROW_X: prdata = CfgDataW'(coef_q[0]);
      REG_COEFF_ROW_Y: prdata = CfgDataW'(coef_q[1]);
      REG_COEFF_ROW_Z: prdata = CfgDataW'(coef_q[2]);
      REG_OFFSETS_X:   prdata = offs_q[0];
      REG_OFFSETS_Y:   prdata = offs_q[1];
      REG_OFFSETS_Z:   prdata = offs_q[2];
      default:         prdata = '0;
    endcase
  end

  // Stage valids and the backward enable chain. A stage loads when it is
  // empty or when the stage after it loads in the same cycle.
  logic v1_q, v2_q, v3_q, v4_q, vo_q;
  logic en1, en2, en3, en4, eno;

  assign eno = !vo_q || bounds_o.ready;
  assign en4 = !v4_q || eno;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign box_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) v1_q <= box_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (eno) vo_q <= v4_q;
    end
  end

  // Stage 1: bound minus center, per input axis and per bound.
  logic signed [CoordW-1:0] bnd   [NumAxes][2];
  logic signed [DiffW-1:0]  dif_d [NumAxes][2];
  logic signed [DiffW-1:0]  dif_q [NumAxes][2];

  always_comb begin
    bnd[0][0] = box_i.data.box_x_low;
    bnd[0][1] = box_i.data.box_x_high;
    bnd[1][0] = box_i.data.box_y_low;
    bnd[1][1] = box_i.data.box_y_high;
    bnd[2][0] = box_i.data.box_z_low;
    bnd[2][1] = box_i.data.box_z_high;
    for (int k = 0; k < NumAxes; k++) begin
      for (int b = 0; b < 2; b++) begin
        dif_d[k][b] = $signed({bnd[k][b][CoordW-1], bnd[k][b]})
                    - $signed({offs_q[k][CoordW-1], offs_q[k][CoordW-1:0]});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) dif_q <= dif_d;
  end

  // Stage 2: one product per output axis, input axis and bound.
  logic signed [ProdW-1:0] prd_d [NumAxes][NumAxes][2];
  logic signed [ProdW-1:0] prd_q [NumAxes][NumAxes][2];

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      for (int k = 0; k < NumAxes; k++) begin
        for (int b = 0; b < 2; b++) begin
          prd_d[a][k][b] = $signed(coef_q[a][CoefW*k +: CoefW]) * dif_q[k][b];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) prd_q <= prd_d;
  end

  // Stage 3: smaller and larger of the two products of each term.
  logic signed [ProdW-1:0] lo3_d [NumAxes][NumAxes];
  logic signed [ProdW-1:0] hi3_d [NumAxes][NumAxes];
  logic signed [ProdW-1:0] lo3_q [NumAxes][NumAxes];
  logic signed [ProdW-1:0] hi3_q [NumAxes][NumAxes];

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      for (int k = 0; k < NumAxes; k++) begin
        if (prd_q[a][k][0] < prd_q[a][k][1]) begin
          lo3_d[a][k] = prd_q[a][k][0];
          hi3_d[a][k] = prd_q[a][k][1];
        end else begin
          lo3_d[a][k] = prd_q[a][k][1];
          hi3_d[a][k] = prd_q[a][k][0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      lo3_q <= lo3_d;
      hi3_q <= hi3_d;
    end
  end

  // Stage 4: sum of the extreme terms plus the rounding bias.
  logic signed [SumW-1:0] slo_d [NumAxes];
  logic signed [SumW-1:0] shi_d [NumAxes];
  logic signed [SumW-1:0] slo_q [NumAxes];
  logic signed [SumW-1:0] shi_q [NumAxes];

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      slo_d[a] = SumW'(lo3_q[a][0]) + SumW'(lo3_q[a][1]) + SumW'(lo3_q[a][2])
               + $signed(RoundBias);
      shi_d[a] = SumW'(hi3_q[a][0]) + SumW'(hi3_q[a][1]) + SumW'(hi3_q[a][2])
               + $signed(RoundBias);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      slo_q <= slo_d;
      shi_q <= shi_d;
    end
  end

  // Stage 5: drop the fraction, add translation and center, saturate.
  function automatic logic signed [CoordW-1:0] finish(
    input logic signed [SumW-1:0]     s,
    input logic        [CfgDataW-1:0] offs
  );
    logic signed [ValW-1:0] r;
    logic signed [ValW-1:0] t;
    logic signed [ValW-1:0] c;
    logic signed [ValW-1:0] v;
    r = ValW'($signed(s[SumW-1:FracBits]));
    t = ValW'($signed(offs[CfgDataW-1:CoordW]));
    c = ValW'($signed(offs[CoordW-1:0]));
    v = r + t + c;
    if (v[ValW-1:CoordW-1] != {(ValW-CoordW+1){v[ValW-1]}}) begin
      finish = v[ValW-1] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
    end else begin
      finish = v[CoordW-1:0];
    end
  endfunction

  bounds_t out_d, out_q;

  always_comb begin
    out_d.mapped_x_low  = finish(slo_q[0], offs_q[0]);
    out_d.mapped_x_high = finish(shi_q[0], offs_q[0]);
    out_d.mapped_y_low  = finish(slo_q[1], offs_q[1]);
    out_d.mapped_y_high = finish(shi_q[1], offs_q[1]);
    out_d.mapped_z_low  = finish(slo_q[2], offs_q[2]);
    out_d.mapped_z_high = finish(shi_q[2], offs_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (eno) out_q <= out_d;
  end

  assign bounds_o.valid = vo_q;
  assign bounds_o.data  = out_q;

  // Checks.
  logic [4:0] vld;
  logic       in_fire, out_fire;

  assign vld      = {v1_q, v2_q, v3_q, v4_q, vo_q};
  assign in_fire  = box_i.valid && box_i.ready;
  assign out_fire = bounds_o.valid && bounds_o.ready;

  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> $countones(vld) ==
             $past($countones(vld)) + int'($past(in_fire)) - int'($past(out_fire)))
    else $error("pipeline occupancy does not match transfers");

  a_ready_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !box_i.ready |-> (vld == 5'b11111) && !bounds_o.ready)
    else $error("input held off without a full, stalled pipeline");

  a_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bounds_o.valid |-> (out_q.mapped_x_low <= out_q.mapped_x_high)
                    && (out_q.mapped_y_low <= out_q.mapped_y_high)
                    && (out_q.mapped_z_low <= out_q.mapped_z_high))
    else $error("mapped low bound above high bound");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr && (reg_idx == REG_OFFSETS_X) |=> offs_q[0] == $past(pwdata))
    else $error("offset register write lost");

endmodule
